// File: src/ssm_pkg.sv
package ssm_pkg;

   // matrix geometry
   localparam int ROWS   = 8;
   localparam int COLS   = 8;
   localparam int TOTAL  = ROWS * COLS;
   localparam int WORD_W = 32;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int CNT_W  = $clog2(TOTAL + 1);

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic signed [WORD_W-1:0] word_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic     load_wr;      // store the accepted word at the load position
      logic     cmp_wr;       // compare the read pair, write lower word to addr_a on swap
      logic     wr2;          // second half of a swap: held upper word to addr_b
      logic     clr_swapped;  // start of a new round
      addr_type addr_a;
      addr_type addr_b;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic load_last;  // load position is the final cell
      logic gt;         // word at addr_a greater than word at addr_b
      logic swapped;    // a swap happened in this round
   } status_type;

endpackage

// File: src/shear_sort_snake_matrix.sv
// Shear sort of a ROWS x COLS matrix of signed 32-bit words into snake order
// (even rows ascending left to right, odd rows ascending right to left).
// Words are loaded one per cycle in row-major order while busy is low; the
// transaction that carries the last word starts the sort and raises busy.
// The sort is done in place in a single dual-read RAM: each round visits
// ROWS*(COLS-1) row pairs and (ROWS-1)*COLS column pairs, one pair at a time,
// through a read state, a compare state and, on a swap, a second write state
// (one write port), repeated until a round makes no swap. The sorted matrix
// is then streamed out in row-major order, one word per cycle on rsp_valid
// with rsp_last on the final word. The receiver cannot stall the stream: it
// must take every word in the cycle rsp_valid is high. busy drops the cycle
// after the last word, and the next matrix may start loading then.
module shear_sort_snake_matrix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_value_res,
   output logic                     rsp_last
);

   import ssm_pkg::*;

   cmd_type    cmd;
   status_type status;
   word_type   rd_word;

   // sequencer
   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last)
   );

   // matrix store and compare
   ssm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_value (req_value),
      .rd_word   (rd_word)
   );

   assign rsp_value_res = rd_word;

   // results only come out while the block is busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // output burst is contiguous up to the final word
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap in output burst");

   // block returns to loading right after the final word
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !busy && !rsp_valid)
      else $error("not idle after final word");

   // no write from sort and load in the same cycle
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.load_wr |-> !cmd.cmp_wr && !cmd.wr2)
      else $error("load overlaps sort write");

endmodule

// File: src/ssm_ram.sv
module ssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// File: src/ssm_datapath.sv
module ssm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ssm_pkg::cmd_type    cmd,
   output ssm_pkg::status_type status,
   input  ssm_pkg::word_type   req_value,
   output ssm_pkg::word_type   rd_word
);

   import ssm_pkg::*;

   addr_type load_cnt_ff, load_cnt_in;
   logic     swapped_ff, swapped_in;
   word_type hold_ff, hold_in;
   word_type rd_a, rd_b;
   logic     wr_en;
   addr_type wr_addr;
   word_type wr_data;
   logic     last_pos;
   logic     swap_now;

   // matrix store
   ssm_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TOTAL)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (cmd.addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (cmd.addr_b),
      .rd_data_b (rd_b)
   );

   // signed compare of the registered pair
   assign last_pos = (load_cnt_ff == addr_type'(TOTAL - 1));
   assign swap_now = cmd.cmp_wr && (rd_a > rd_b);

   // write port select: load, first swap write, second swap write
   always_comb begin
      wr_en   = cmd.load_wr || swap_now || cmd.wr2;
      wr_addr = cmd.addr_b;
      wr_data = hold_ff;
      if (cmd.load_wr) begin
         wr_addr = load_cnt_ff;
         wr_data = req_value;
      end else if (cmd.cmp_wr) begin
         wr_addr = cmd.addr_a;
         wr_data = rd_b;
      end
   end

   // load position, swap flag and held upper word
   always_comb begin
      load_cnt_in = load_cnt_ff;
      if (cmd.load_wr) begin
         load_cnt_in = last_pos ? '0 : load_cnt_ff + addr_type'(1);
      end
      swapped_in = swapped_ff;
      if (cmd.clr_swapped) begin
         swapped_in = 1'b0;
      end else if (swap_now) begin
         swapped_in = 1'b1;
      end
      hold_in = cmd.cmp_wr ? rd_a : hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         swapped_ff  <= 1'b0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         swapped_ff  <= swapped_in;
      end
      hold_ff <= hold_in;
   end

   assign status.load_last = last_pos;
   assign status.gt        = rd_a > rd_b;
   assign status.swapped   = swapped_ff || swap_now;
   assign rd_word          = rd_a;

endmodule

// File: src/ssm_ctrl.sv
module ssm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ssm_pkg::status_type status,
   output ssm_pkg::cmd_type    cmd,
   output logic                rsp_valid,
   output logic                rsp_last
);

   import ssm_pkg::*;

   typedef enum logic [5:0] {
      ST_LOAD   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_CMP    = 6'b000100,
      ST_SWAP   = 6'b001000,
      ST_OUT_RD = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_ROW_EVEN = 3'b001,
      PH_ROW_ODD  = 3'b010,
      PH_COL      = 3'b100
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      out_cnt_ff, out_cnt_in;

   // position of the next pair in the round
   phase_type             adv_phase;
   logic [ROW_W-1:0]      adv_row;
   logic [COL_W-1:0]      adv_col;
   logic                  adv_round_end;
   addr_type              pos;
   addr_type              pair_a, pair_b;
   logic                  out_done;

   assign pos      = addr_type'(int'(row_ff) * COLS + int'(col_ff));
   assign out_done = (out_cnt_ff == CNT_W'(TOTAL));

   // step to the next compare pair: even rows, odd rows, then columns
   always_comb begin
      adv_phase     = phase_ff;
      adv_row       = row_ff;
      adv_col       = col_ff;
      adv_round_end = 1'b0;
      case (phase_ff)
         PH_ROW_EVEN: begin
            if (col_ff == COL_W'(COLS - 2)) begin
               if (int'(row_ff) + 2 >= ROWS) begin
                  adv_phase = PH_ROW_ODD;
                  adv_row   = ROW_W'(1);
                  adv_col   = COL_W'(COLS - 1);
               end else begin
                  adv_row = ROW_W'(int'(row_ff) + 2);
                  adv_col = '0;
               end
            end else begin
               adv_col = col_ff + COL_W'(1);
            end
         end
         PH_ROW_ODD: begin
            if (col_ff == COL_W'(1)) begin
               if (int'(row_ff) + 2 >= ROWS) begin
                  adv_phase = PH_COL;
                  adv_row   = '0;
                  adv_col   = '0;
               end else begin
                  adv_row = ROW_W'(int'(row_ff) + 2);
                  adv_col = COL_W'(COLS - 1);
               end
            end else begin
               adv_col = col_ff - COL_W'(1);
            end
         end
         PH_COL: begin
            if (col_ff == COL_W'(COLS - 1)) begin
               adv_col = '0;
               if (row_ff == ROW_W'(ROWS - 2)) begin
                  adv_round_end = 1'b1;
                  adv_phase     = PH_ROW_EVEN;
                  adv_row       = '0;
               end else begin
                  adv_row = row_ff + ROW_W'(1);
               end
            end else begin
               adv_col = col_ff + COL_W'(1);
            end
         end
         default: begin
            adv_phase = PH_ROW_EVEN;
            adv_row   = '0;
            adv_col   = '0;
         end
      endcase
   end

   // pair addresses and output read address
   always_comb begin
      pair_a = pos;
      pair_b = pos + addr_type'(COLS);
      case (phase_ff)
         PH_ROW_EVEN: pair_b = pos + addr_type'(1);
         PH_ROW_ODD:  pair_b = pos - addr_type'(1);
         PH_COL:      pair_b = pos + addr_type'(COLS);
         default:     pair_b = pos + addr_type'(COLS);
      endcase
      if (state_ff == ST_OUT_RD || state_ff == ST_OUT) begin
         pair_a = out_cnt_ff[ADDR_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      out_cnt_in      = out_cnt_ff;
      cmd.addr_a      = pair_a;
      cmd.addr_b      = pair_b;
      cmd.load_wr     = 1'b0;
      cmd.cmp_wr      = 1'b0;
      cmd.wr2         = 1'b0;
      cmd.clr_swapped = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load_wr = start;
            if (start && status.load_last) begin
               cmd.clr_swapped = 1'b1;
               phase_in        = PH_ROW_EVEN;
               row_in          = '0;
               col_in          = '0;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP, ST_SWAP: begin
            cmd.cmp_wr = (state_ff == ST_CMP);
            cmd.wr2    = (state_ff == ST_SWAP);
            if (state_ff == ST_CMP && status.gt) begin
               state_in = ST_SWAP;
            end else begin
               phase_in = adv_phase;
               row_in   = adv_row;
               col_in   = adv_col;
               state_in = ST_READ;
               if (adv_round_end) begin
                  if (status.swapped) begin
                     cmd.clr_swapped = 1'b1;
                  end else begin
                     out_cnt_in = '0;
                     state_in   = ST_OUT_RD;
                  end
               end
            end
         end
         ST_OUT_RD: begin
            out_cnt_in = out_cnt_ff + CNT_W'(1);
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            out_cnt_in = out_cnt_ff + CNT_W'(1);
            if (out_done) begin
               out_cnt_in = '0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         phase_ff   <= PH_ROW_EVEN;
         row_ff     <= '0;
         col_ff     <= '0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_last  = (state_ff == ST_OUT) && out_done;

endmodule

// File: verif/shear_sort_snake_matrix_test.sv
module shear_sort_snake_matrix_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ssm_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MATRICES    = 6;
   localparam int DRAIN_WAIT  = 400;

   // ways of filling one random matrix
   typedef enum int {
      FILL_FULL,
      FILL_NARROW,
      FILL_ASCEND,
      FILL_DESCEND,
      FILL_SAME
   } fill_kind_type;

   typedef struct {
      word_type value_res;
      logic     last;
   } sorted_word_type;

   // expected sorted output built from the accepted words
   class snake_matrix_scoreboard;
      word_type        matrix [TOTAL];
      int unsigned     loaded;
      sorted_word_type sorted_q[$];
      int unsigned     errors;

      // swap when the word at hi_pos is greater than the one at lo_pos
      function void order_pair(int hi_pos, int lo_pos, inout bit swapped);
         word_type t;
         if (matrix[hi_pos] > matrix[lo_pos]) begin
            t = matrix[hi_pos];
            matrix[hi_pos] = matrix[lo_pos];
            matrix[lo_pos] = t;
            swapped = 1'b1;
         end
      endfunction

      // shear-sort rounds until one makes no swap
      function void shear_sort();
         bit swapped;
         do begin
            swapped = 1'b0;
            for (int r = 0; r < ROWS; r += 2)
               for (int c = 0; c + 1 < COLS; c++)
                  order_pair(r * COLS + c, r * COLS + c + 1, swapped);
            for (int r = 1; r < ROWS; r += 2)
               for (int c = COLS - 1; c > 0; c--)
                  order_pair(r * COLS + c, r * COLS + c - 1, swapped);
            for (int r = 0; r + 1 < ROWS; r++)
               for (int c = 0; c < COLS; c++)
                  order_pair(r * COLS + c, (r + 1) * COLS + c, swapped);
         end while (swapped);
      endfunction

      // accepted input transaction
      function void note_word(word_type v);
         sorted_word_type w;
         matrix[loaded] = v;
         loaded++;
         if (loaded == TOTAL) begin
            shear_sort();
            for (int k = 0; k < TOTAL; k++) begin
               w.value_res = matrix[k];
               w.last      = (k == TOTAL - 1);
               sorted_q.push_back(w);
            end
            loaded = 0;
         end
      endfunction

      // accepted result transaction
      function void check_word(word_type v, logic last);
         sorted_word_type w;
         if (sorted_q.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %0d last %0b",
                     $time, v, last);
            errors++;
            return;
         end
         w = sorted_q.pop_front();
         if (v !== w.value_res) begin
            $display("%0t: value_res mismatch: expected %0d, actual %0d",
                     $time, w.value_res, v);
            errors++;
         end
         if (last !== w.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   word_type req_value;
   logic     rsp_valid;
   word_type rsp_value_res;
   logic     rsp_last;

   int unsigned cycle_count = 0;

   snake_matrix_scoreboard board = new();

   shear_sort_snake_matrix u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_value_res (rsp_value_res),
      .rsp_last      (rsp_last)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // cycle counter for the timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_word(rsp_value_res, rsp_last);
      end
   end

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap(bit gaps_on);
      int unsigned r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic word_type fill_word(fill_kind_type kind, int k, word_type base);
      case (kind)
         FILL_NARROW:  return $urandom_range(0, 7) - 4;
         FILL_ASCEND:  return base + k;
         FILL_DESCEND: return (TOTAL - k) * 1000 - 32000;
         FILL_SAME:    return base;
         default:      return $urandom;
      endcase
   endfunction

   // one input transaction, then an optional idle stretch
   task automatic send_word(word_type v, int unsigned gap);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      board.note_word(v);
      if (gap > 0) begin
         @(negedge clock);
         start     <= 1'b0;
         req_value <= $urandom;
         repeat (gap - 1) begin
            @(negedge clock);
            req_value <= $urandom;
         end
      end
   endtask

   // timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // stimulus
   initial begin
      word_type      specials [16];
      word_type      v;
      word_type      base;
      fill_kind_type kind;
      bit            gaps_on;

      specials = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
                   32'sh00000001, 32'sh7ffffffe, 32'sh80000001, 32'sh7fffffff,
                   32'sh80000000, 32'sh00000000, 32'sh00000000, 32'shffffffff,
                   32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff, 32'shffff0000};

      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, ties and a descending tail
      gaps_on = 1'b1;
      for (int k = 0; k < TOTAL; k++) begin
         if (k < 16) v = specials[k];
         else v = (TOTAL - 1 - k) / 2 - 8;
         send_word(v, pick_gap(gaps_on));
      end

      // random matrices of varied shape
      for (int m = 1; m < MATRICES; m++) begin
         kind    = (m == 1) ? FILL_FULL : fill_kind_type'($urandom_range(0, 4));
         base    = $urandom;
         if (kind == FILL_ASCEND) base = base >>> 8;
         gaps_on = ($urandom_range(0, 2) != 0);
         for (int k = 0; k < TOTAL; k++) begin
            send_word(fill_word(kind, k, base), pick_gap(gaps_on));
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // drain
      while (board.sorted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/ssm_pkg.sv
src/ssm_ram.sv
src/ssm_datapath.sv
src/ssm_ctrl.sv
src/shear_sort_snake_matrix.sv
verif/shear_sort_snake_matrix_test.sv
